FILE: hdl/qsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_pkg
// Shared types and constants of the quoted string unescaper: decode state,
// result item layout, character codes and the record length limit.
// ----------------------------------------------------------------------------
package qsu_pkg;

    localparam int LenW = 15;

    localparam logic [LenW-1:0] MaxLen = LenW'(16384);

    localparam logic [7:0] ChNul    = 8'h00;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChEsc    = 8'h1B;
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;

    typedef enum logic [1:0] {
        PhIdle   = 2'd0,
        PhQuoted = 2'd1,
        PhEscape = 2'd2,
        PhPlain  = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase          phase;
        logic            after_cr;
        logic [LenW-1:0] byte_count;
    } t_state;

    typedef struct packed {
        logic [7:0]      out_byte;
        logic            record_done;
        logic            truncated;
        logic [LenW-1:0] record_length;
    } t_result;

endpackage

FILE: hdl/qsu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_decode
// Next-state and result logic for one input item: quoted and plain-line
// decoding, escape translation, NUL drop and length limit.
// ----------------------------------------------------------------------------
module qsu_decode (
    input  qsu_pkg::t_state  i_state,
    input  logic             i_quoted_en,
    input  logic [7:0]       i_in_byte,
    input  logic             i_end_of_input,
    output qsu_pkg::t_state  o_state,
    output logic             o_has_result,
    output qsu_pkg::t_result o_result
);

    function automatic logic [7:0] unescape(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'h65, 8'h45: r = qsu_pkg::ChEsc;
            8'h6E, 8'h4E: r = qsu_pkg::ChLf;
            8'h72, 8'h52: r = qsu_pkg::ChCr;
            8'h74, 8'h54: r = qsu_pkg::ChTab;
            default:      r = b;
        endcase
        return r;
    endfunction

    always_comb begin
        logic       do_emit;
        logic [7:0] emit_b;
        logic       do_fin;
        logic       fin_tr;
        logic       plain_go;
        logic       plain_acr;

        do_emit   = 1'b0;
        emit_b    = i_in_byte;
        do_fin    = 1'b0;
        fin_tr    = 1'b0;
        plain_go  = 1'b0;
        plain_acr = i_state.after_cr;
        o_state      = i_state;
        o_has_result = 1'b0;
        o_result     = '0;

        if (i_end_of_input) begin
            do_fin = 1'b1;
        end else begin
            case (i_state.phase)
                qsu_pkg::PhIdle: begin
                    if (i_quoted_en && i_in_byte == qsu_pkg::ChQuote) begin
                        o_state.phase = qsu_pkg::PhQuoted;
                    end else begin
                        o_state.phase    = qsu_pkg::PhPlain;
                        o_state.after_cr = 1'b0;
                        plain_go         = 1'b1;
                        plain_acr        = 1'b0;
                    end
                end
                qsu_pkg::PhQuoted: begin
                    if (i_in_byte == qsu_pkg::ChNul) begin
                        do_emit = 1'b0;
                    end else if (i_in_byte == qsu_pkg::ChQuote) begin
                        do_fin = 1'b1;
                    end else if (i_in_byte == qsu_pkg::ChBslash) begin
                        o_state.phase = qsu_pkg::PhEscape;
                    end else begin
                        do_emit = 1'b1;
                    end
                end
                qsu_pkg::PhEscape: begin
                    if (i_in_byte != qsu_pkg::ChNul) begin
                        o_state.phase = qsu_pkg::PhQuoted;
                        do_emit       = 1'b1;
                        emit_b        = unescape(i_in_byte);
                    end
                end
                default: begin
                    plain_go = 1'b1;
                end
            endcase
        end

        if (plain_go && i_in_byte != qsu_pkg::ChNul) begin
            if (i_in_byte == qsu_pkg::ChLf && !plain_acr) begin
                do_fin = 1'b1;
            end else begin
                do_emit          = 1'b1;
                o_state.after_cr = (i_in_byte == qsu_pkg::ChCr);
            end
        end

        if (do_emit) begin
            if (i_state.byte_count >= qsu_pkg::MaxLen) begin
                do_fin = 1'b1;
                fin_tr = 1'b1;
            end else begin
                o_state.byte_count = i_state.byte_count + qsu_pkg::LenW'(1);
                o_has_result       = 1'b1;
                o_result.out_byte  = emit_b;
            end
        end

        if (do_fin) begin
            o_has_result           = 1'b1;
            o_result.out_byte      = 8'h00;
            o_result.record_done   = 1'b1;
            o_result.truncated     = fin_tr;
            o_result.record_length = i_state.byte_count;
            o_state.phase          = qsu_pkg::PhIdle;
            o_state.after_cr       = 1'b0;
            o_state.byte_count     = '0;
        end
    end

endmodule

FILE: hdl/quoted_string_unescaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_string_unescaper
// Decodes a byte stream of string records (quoted with backslash escapes,
// or plain lines) into data bytes and an end-of-record item with length.
// ----------------------------------------------------------------------------
// Takes one item per cycle with no bubbles while the output is not stalled:
// an input register holds the byte, one pass of decode logic updates the
// record state and fills a result register, so an item's result reaches the
// outputs through the input register and then the result register. Bytes that
// produce nothing (opening quote, backslash, NUL) leave the pipe without
// waiting on the output. Input stall follows output stall combinationally.
// Write the quoted-format enable only while no items are in flight.
// ----------------------------------------------------------------------------
module quoted_string_unescaper (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic                     i_cfg_wr_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [7:0]               i_in_byte,
    input  logic                     i_end_of_input,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [7:0]               o_out_byte,
    output logic                     o_record_done,
    output logic                     o_truncated,
    output logic [qsu_pkg::LenW-1:0] o_record_length
);

    logic             r_quoted_en;
    logic             r_s1_valid;
    logic [7:0]       r_s1_byte;
    logic             r_s1_eoi;
    qsu_pkg::t_state  r_state;
    qsu_pkg::t_state  n_state;
    logic             r_out_valid;
    qsu_pkg::t_result r_out;
    qsu_pkg::t_result n_out;
    logic             has_res;
    logic             out_free;
    logic             s1_adv;
    logic             in_acc;

    qsu_decode u_decode (
        .i_state        (r_state),
        .i_quoted_en    (r_quoted_en),
        .i_in_byte      (r_s1_byte),
        .i_end_of_input (r_s1_eoi),
        .o_state        (n_state),
        .o_has_result   (has_res),
        .o_result       (n_out)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && (!has_res || out_free);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quoted_en <= 1'b1;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: qsu_pkg::PhIdle, after_cr: 1'b0, byte_count: '0};
        end else begin
            if (i_cfg_wr_en) begin
                r_quoted_en <= i_cfg_wr_data;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_state <= n_state;
            end
            if (s1_adv && has_res) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_byte <= i_in_byte;
            r_s1_eoi  <= i_end_of_input;
        end
        if (s1_adv && has_res) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out.out_byte;
    assign o_record_done   = r_out.record_done;
    assign o_truncated     = r_out.truncated;
    assign o_record_length = r_out.record_length;

endmodule

FILE: hdl/qsu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_checker
// Port-level checks of the quoted string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
module qsu_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic [7:0]               o_out_byte,
    input logic                     o_record_done,
    input logic                     o_truncated,
    input logic [qsu_pkg::LenW-1:0] o_record_length
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_record_done) && $stable(o_record_length))
        else $error("stalled output item changed");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_record_done |-> !o_truncated && o_record_length == '0)
        else $error("data item carries end-of-record fields");

    a_trunc_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_truncated |-> o_record_done && o_out_byte == 8'h00
            && o_record_length == qsu_pkg::MaxLen)
        else $error("truncated record with wrong length");

endmodule

bind quoted_string_unescaper qsu_checker u_qsu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_out_byte      (o_out_byte),
    .o_record_done   (o_record_done),
    .o_truncated     (o_truncated),
    .o_record_length (o_record_length)
);
